// File: rtl/core/emrt_pkg.sv
// ----------------------------------------------------------------------------
// emrt_pkg
// Shared types and codes of the exact-match route table: operation and
// status codes, field widths, and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package emrt_pkg;

	localparam int DEST_W    = 32;
	localparam int PLEN_W    = 6;
	localparam int GW_W      = 32;
	localparam int IFACE_W   = 8;
	localparam int STATUS_W  = 3;
	localparam int CMD_W     = 2;
	localparam int KEY_W     = DEST_W + PLEN_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_LOOKUP = 2'd3
	} cmd_t;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNCHANGED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

	// commands from the controller to the datapath
	typedef struct packed {
		logic clear_wr;
		logic capture;
		logic rd_en;
		logic commit;
	} emrt_ctl_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic cnt_last;
	} emrt_sts_t;

endpackage

// File: rtl/core/exact_match_route_table_core.sv
// ----------------------------------------------------------------------------
// exact_match_route_table_core
// The result strobe is registered after the scan, the drain state and the
// commit state; one entry of the key and route stores is read per cycle during
// the scan. A new item may start in the cycle the previous result is strobed.
// The receiver cannot stall.
// Reset: asynchronous; a clearing pass then zeroes the valid marks, one entry a
// cycle, keeping busy high until the pass ends.
// ----------------------------------------------------------------------------
module exact_match_route_table_core #(
	parameter int TABLE_DEPTH = 64,
	parameter int IFACE_BITS  = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [emrt_pkg::CMD_W-1:0]    cmd,
	input  logic [emrt_pkg::DEST_W-1:0]   dest_addr,
	input  logic [emrt_pkg::PLEN_W-1:0]   prefix_len,
	input  logic [emrt_pkg::GW_W-1:0]     gateway_addr,
	input  logic [emrt_pkg::IFACE_W-1:0]  out_iface,
	output logic                          done,
	output logic [emrt_pkg::STATUS_W-1:0] status,
	output logic                          hit,
	output logic [emrt_pkg::GW_W-1:0]     found_gateway,
	output logic [emrt_pkg::IFACE_W-1:0]  found_iface
);
	import emrt_pkg::*;

	emrt_ctl_t ctl;
	emrt_sts_t sts;

	emrt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.ctl   (ctl),
		.busy  (busy),
		.done  (done)
	);

	emrt_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.IFACE_BITS (IFACE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cmd          (cmd),
		.dest_addr    (dest_addr),
		.prefix_len   (prefix_len),
		.gateway_addr (gateway_addr),
		.out_iface    (out_iface),
		.status       (status),
		.hit          (hit),
		.found_gateway(found_gateway),
		.found_iface  (found_iface)
	);

endmodule

// File: rtl/core/emrt_ram.sv
// ----------------------------------------------------------------------------
// emrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module emrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/emrt_ctrl.sv
// ----------------------------------------------------------------------------
// emrt_ctrl
// Controller of the route table: clearing pass after reset, item accept,
// table scan, drain of the last read, and commit with result strobe.
// ----------------------------------------------------------------------------
module emrt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  emrt_pkg::emrt_sts_t sts,
	output emrt_pkg::emrt_ctl_t ctl,
	output logic              busy,
	output logic              done
);
	import emrt_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (sts.cnt_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.cnt_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		ctl.clear_wr = (state_q == S_CLEAR);
		ctl.capture  = (state_q == S_IDLE) && start;
		ctl.rd_en    = (state_q == S_SCAN);
		ctl.commit   = (state_q == S_COMMIT);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// File: rtl/core/emrt_datapath.sv
// ----------------------------------------------------------------------------
// emrt_datapath
// Datapath of the route table: item registers, scan counter, key and route
// stores, per-entry compare, and the result registers.
// ----------------------------------------------------------------------------
module emrt_datapath #(
	parameter int TABLE_DEPTH = 64,
	parameter int IFACE_BITS  = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  emrt_pkg::emrt_ctl_t             ctl,
	output emrt_pkg::emrt_sts_t             sts,
	input  logic [emrt_pkg::CMD_W-1:0]      cmd,
	input  logic [emrt_pkg::DEST_W-1:0]     dest_addr,
	input  logic [emrt_pkg::PLEN_W-1:0]     prefix_len,
	input  logic [emrt_pkg::GW_W-1:0]       gateway_addr,
	input  logic [emrt_pkg::IFACE_W-1:0]    out_iface,
	output logic [emrt_pkg::STATUS_W-1:0]   status,
	output logic                            hit,
	output logic [emrt_pkg::GW_W-1:0]       found_gateway,
	output logic [emrt_pkg::IFACE_W-1:0]    found_iface
);
	import emrt_pkg::*;

	localparam int AW      = $clog2(TABLE_DEPTH);
	localparam int ROUTE_W = GW_W + IFACE_BITS;
	localparam int KREC_W  = KEY_W + 1;   // valid mark on top of the key

	cmd_t               cmd_q;
	logic [KEY_W-1:0]   key_q;
	logic [ROUTE_W-1:0] route_q;

	logic [AW-1:0]      cnt_q;
	logic               vld_s1;
	logic [AW-1:0]      idx_s1;

	logic               match_q;
	logic [AW-1:0]      match_idx_q;
	logic [ROUTE_W-1:0] match_route_q;
	logic               free_q;
	logic [AW-1:0]      free_idx_q;

	logic [KREC_W-1:0]  key_rdata;
	logic [ROUTE_W-1:0] route_rdata;

	logic               key_we;
	logic [AW-1:0]      key_waddr;
	logic [KREC_W-1:0]  key_wdata;
	logic               route_we;
	logic [AW-1:0]      route_waddr;
	logic [STATUS_W-1:0] status_d;

	logic               step;

	assign step         = ctl.clear_wr || ctl.rd_en;
	assign sts.cnt_last = (cnt_q == AW'(TABLE_DEPTH - 1));

	// item registers
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= cmd_t'(cmd);
			key_q   <= {dest_addr, prefix_len};
			route_q <= {gateway_addr, IFACE_BITS'(out_iface)};
		end
	end

	// scan address counter, shared by the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.rd_en;
			if (ctl.capture || (step && sts.cnt_last)) begin
				cnt_q <= '0;
			end else if (step) begin
				cnt_q <= cnt_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
	end

	// first matching entry and first free entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (ctl.capture) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (vld_s1) begin
			if (key_rdata[KEY_W] && (key_rdata[KEY_W-1:0] == key_q) && !match_q) begin
				match_q <= 1'b1;
			end
			if (!key_rdata[KEY_W] && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			if (key_rdata[KEY_W] && (key_rdata[KEY_W-1:0] == key_q) && !match_q) begin
				match_idx_q   <= idx_s1;
				match_route_q <= route_rdata;
			end
			if (!key_rdata[KEY_W] && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	// outcome of the operation and store writes
	always_comb begin
		status_d    = ST_OK;
		key_we      = 1'b0;
		key_waddr   = cnt_q;
		key_wdata   = '0;
		route_we    = 1'b0;
		route_waddr = match_idx_q;
		if (ctl.clear_wr) begin
			key_we = 1'b1;
		end else if (ctl.commit) begin
			case (cmd_q)
				CMD_INSERT: begin
					if (match_q) begin
						status_d = ST_EXISTS;
					end else if (!free_q) begin
						status_d = ST_FULL;
					end else begin
						key_we      = 1'b1;
						key_waddr   = free_idx_q;
						key_wdata   = {1'b1, key_q};
						route_we    = 1'b1;
						route_waddr = free_idx_q;
					end
				end
				CMD_DELETE: begin
					if (!match_q) begin
						status_d = ST_NOT_FOUND;
					end else begin
						key_we    = 1'b1;
						key_waddr = match_idx_q;
						key_wdata = {1'b0, key_q};
					end
				end
				CMD_UPDATE: begin
					if (!match_q) begin
						status_d = ST_NOT_FOUND;
					end else if (match_route_q == route_q) begin
						status_d = ST_UNCHANGED;
					end else begin
						route_we = 1'b1;
					end
				end
				CMD_LOOKUP: begin
					status_d = match_q ? ST_OK : ST_NOT_FOUND;
				end
				default: begin
					status_d = ST_NOT_FOUND;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			status        <= status_d;
			hit           <= match_q;
			found_gateway <= match_q ? match_route_q[ROUTE_W-1:IFACE_BITS] : '0;
			found_iface   <= match_q ? IFACE_W'(match_route_q[IFACE_BITS-1:0]) : '0;
		end
	end

	emrt_ram #(
		.WIDTH(KREC_W),
		.DEPTH(TABLE_DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(key_wdata),
		.raddr(cnt_q),
		.rdata(key_rdata)
	);

	emrt_ram #(
		.WIDTH(ROUTE_W),
		.DEPTH(TABLE_DEPTH)
	) u_route_ram (
		.clk  (clk),
		.we   (route_we),
		.waddr(route_waddr),
		.wdata(route_q),
		.raddr(cnt_q),
		.rdata(route_rdata)
	);

endmodule

// File: tb/exact_match_route_table_core_test.sv
// ----------------------------------------------------------------------------
// exact_match_route_table_core_test
// Self-checking bench for the exact-match route table core: directed corner
// items, a table-full pass and random insert/delete/update/lookup traffic over
// small key pools, each result checked against a cycle-free table predictor.
// ----------------------------------------------------------------------------
module exact_match_route_table_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import emrt_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int IFACE_BITS  = 8;
	localparam int POOL_MAX    = 128;
	localparam logic [IFACE_W-1:0] IFACE_MASK = IFACE_W'((1 << IFACE_BITS) - 1);

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic                hit;
		logic [GW_W-1:0]     gw;
		logic [IFACE_W-1:0]  iface;
	} route_result_t;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                start        = 1'b0;
	logic [CMD_W-1:0]    cmd          = '0;
	logic [DEST_W-1:0]   dest_addr    = '0;
	logic [PLEN_W-1:0]   prefix_len   = '0;
	logic [GW_W-1:0]     gateway_addr = '0;
	logic [IFACE_W-1:0]  out_iface    = '0;
	logic                busy;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic                hit;
	logic [GW_W-1:0]     found_gateway;
	logic [IFACE_W-1:0]  found_iface;

	// predictor copy of the table
	logic                tbl_valid [TABLE_DEPTH];
	logic [KEY_W-1:0]    tbl_key   [TABLE_DEPTH];
	logic [GW_W-1:0]     tbl_gw    [TABLE_DEPTH];
	logic [IFACE_W-1:0]  tbl_iface [TABLE_DEPTH];

	route_result_t       pending_results [$];
	int                  mismatch_count = 0;
	bit                  sender_steady  = 1'b0;

	logic [DEST_W-1:0]   pool_dest [POOL_MAX];
	logic [PLEN_W-1:0]   pool_plen [POOL_MAX];

	exact_match_route_table_core #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.IFACE_BITS (IFACE_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.dest_addr    (dest_addr),
		.prefix_len   (prefix_len),
		.gateway_addr (gateway_addr),
		.out_iface    (out_iface),
		.done         (done),
		.status       (status),
		.hit          (hit),
		.found_gateway(found_gateway),
		.found_iface  (found_iface)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("exact_match_route_table_core regression: fail");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// applies one operation to the table copy and returns its result
	function automatic route_result_t predict_route_op(input cmd_t op,
			input logic [DEST_W-1:0] d, input logic [PLEN_W-1:0] p,
			input logic [GW_W-1:0] g, input logic [IFACE_W-1:0] f);
		route_result_t    r;
		logic [KEY_W-1:0] key;
		logic [IFACE_W-1:0] fm;
		int               slot;
		int               free_idx;
		key      = {d, p};
		fm       = f & IFACE_MASK;
		slot     = -1;
		free_idx = -1;
		r        = '{status: ST_OK, hit: 1'b0, gw: '0, iface: '0};
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (slot < 0 && tbl_valid[i] && tbl_key[i] == key)
				slot = i;
			if (free_idx < 0 && !tbl_valid[i])
				free_idx = i;
		end
		if (slot >= 0) begin
			r.hit   = 1'b1;
			r.gw    = tbl_gw[slot];
			r.iface = tbl_iface[slot];
		end
		case (op)
			CMD_INSERT: begin
				if (slot >= 0)
					r.status = ST_EXISTS;
				else if (free_idx < 0)
					r.status = ST_FULL;
				else begin
					tbl_valid[free_idx] = 1'b1;
					tbl_key[free_idx]   = key;
					tbl_gw[free_idx]    = g;
					tbl_iface[free_idx] = fm;
				end
			end
			CMD_DELETE: begin
				if (slot < 0)
					r.status = ST_NOT_FOUND;
				else
					tbl_valid[slot] = 1'b0;
			end
			CMD_UPDATE: begin
				if (slot < 0)
					r.status = ST_NOT_FOUND;
				else if (tbl_gw[slot] == g && tbl_iface[slot] == fm)
					r.status = ST_UNCHANGED;
				else begin
					tbl_gw[slot]    = g;
					tbl_iface[slot] = fm;
				end
			end
			default: begin
				if (slot < 0)
					r.status = ST_NOT_FOUND;
			end
		endcase
		return r;
	endfunction

	// called at a rising edge; returns at a rising edge with start low
	task automatic send_route_op(input cmd_t op, input logic [DEST_W-1:0] d,
			input logic [PLEN_W-1:0] p, input logic [GW_W-1:0] g,
			input logic [IFACE_W-1:0] f);
		// idle only once the core is free, so the gap is seen on its input
		while (busy !== 1'b0)
			@(posedge clk);
		if (!sender_steady && $urandom_range(0, 99) < 18)
			repeat ($urandom_range(1, 160)) @(posedge clk);
		start        <= 1'b1;
		cmd          <= op;
		dest_addr    <= d;
		prefix_len   <= p;
		gateway_addr <= g;
		out_iface    <= f;
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.push_back(predict_route_op(op, d, p, g, f));
		start <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin : check_results
		route_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0)
				report_mismatch("result item with nothing pending");
			else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d", status,
						want.status));
				if (hit !== want.hit)
					report_mismatch($sformatf("hit got %0b want %0b", hit, want.hit));
				if (found_gateway !== want.gw)
					report_mismatch($sformatf("found_gateway got %h want %h",
						found_gateway, want.gw));
				if (found_iface !== want.iface)
					report_mismatch($sformatf("found_iface got %h want %h",
						found_iface, want.iface));
			end
		end
	end

	task automatic wait_results_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_cases();
		send_route_op(CMD_LOOKUP, 32'h0, 6'd0, 32'h0, 8'h00);
		send_route_op(CMD_DELETE, 32'h0, 6'd0, 32'h0, 8'h00);
		send_route_op(CMD_UPDATE, 32'h0, 6'd0, 32'h1, 8'h01);
		send_route_op(CMD_INSERT, 32'h0, 6'd0, 32'h0, 8'h00);
		send_route_op(CMD_INSERT, 32'hffff_ffff, 6'd63, 32'hffff_ffff, 8'hff);
		// same address, other prefix length is another key
		send_route_op(CMD_INSERT, 32'hffff_ffff, 6'd32, 32'h1234_5678, 8'h01);
		send_route_op(CMD_INSERT, 32'hffff_ffff, 6'd63, 32'h0bad_cafe, 8'h3c);
		send_route_op(CMD_LOOKUP, 32'hffff_ffff, 6'd63, 32'h0, 8'h00);
		send_route_op(CMD_LOOKUP, 32'hffff_ffff, 6'd33, 32'h0, 8'h00);
		send_route_op(CMD_UPDATE, 32'hffff_ffff, 6'd63, 32'hffff_ffff, 8'hff);
		send_route_op(CMD_UPDATE, 32'hffff_ffff, 6'd63, 32'hffff_ffff, 8'h7f);
		send_route_op(CMD_UPDATE, 32'h0, 6'd0, 32'ha5a5_a5a5, 8'h5a);
		send_route_op(CMD_LOOKUP, 32'h0, 6'd0, 32'h0, 8'h00);
		send_route_op(CMD_DELETE, 32'h0, 6'd0, 32'h0, 8'h00);
		send_route_op(CMD_LOOKUP, 32'h0, 6'd0, 32'h0, 8'h00);
		send_route_op(CMD_INSERT, 32'h0, 6'd0, 32'h5a5a_5a5a, 8'ha5);
		send_route_op(CMD_DELETE, 32'hffff_ffff, 6'd32, 32'h0, 8'h00);
		send_route_op(CMD_DELETE, 32'hffff_ffff, 6'd63, 32'h0, 8'h00);
		send_route_op(CMD_DELETE, 32'h0, 6'd0, 32'h0, 8'h00);
		send_route_op(CMD_LOOKUP, 32'hffff_ffff, 6'd63, 32'h0, 8'h00);
		send_route_op(CMD_INSERT, 32'h8000_0001, 6'd1, 32'h5555_5555, 8'haa);
		// gateway kept, interface changed
		send_route_op(CMD_UPDATE, 32'h8000_0001, 6'd1, 32'h5555_5555, 8'h55);
		send_route_op(CMD_UPDATE, 32'h8000_0001, 6'd1, 32'h5555_5555, 8'h55);
		send_route_op(CMD_DELETE, 32'h8000_0001, 6'd1, 32'h0, 8'h00);
	endtask

	task automatic test_table_full();
		logic [DEST_W-1:0] fill_dest [TABLE_DEPTH];
		logic [PLEN_W-1:0] fill_plen [TABLE_DEPTH];
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			fill_dest[i] = {16'($urandom), 16'(i)};
			fill_plen[i] = PLEN_W'(i);
			send_route_op(CMD_INSERT, fill_dest[i], fill_plen[i], $urandom,
				8'($urandom));
		end
		send_route_op(CMD_INSERT, 32'hdead_0000, 6'd7, $urandom, 8'($urandom));
		// presence is checked before the free slot search
		send_route_op(CMD_INSERT, fill_dest[5], fill_plen[5], $urandom, 8'($urandom));
		send_route_op(CMD_LOOKUP, fill_dest[TABLE_DEPTH-1], fill_plen[TABLE_DEPTH-1],
			32'h0, 8'h00);
		send_route_op(CMD_DELETE, fill_dest[10], fill_plen[10], 32'h0, 8'h00);
		fill_dest[10] = 32'hdead_0000;
		fill_plen[10] = 6'd7;
		send_route_op(CMD_INSERT, fill_dest[10], fill_plen[10], $urandom, 8'($urandom));
		send_route_op(CMD_LOOKUP, fill_dest[10], fill_plen[10], 32'h0, 8'h00);
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_route_op(CMD_DELETE, fill_dest[i], fill_plen[i], 32'h0, 8'h00);
	endtask

	task automatic test_random_ops(input int n_items, input int pool_size,
			input int insert_pct);
		cmd_t              op;
		int                pick;
		int                roll;
		logic [DEST_W-1:0] d;
		logic [PLEN_W-1:0] p;
		logic [GW_W-1:0]   g;
		logic [IFACE_W-1:0] f;
		for (int i = 0; i < pool_size; i++) begin
			pool_dest[i] = $urandom;
			pool_plen[i] = ($urandom_range(0, 1) != 0) ? PLEN_W'($urandom_range(0, 32))
				: PLEN_W'($urandom_range(0, 63));
		end
		for (int n = 0; n < n_items; n++) begin
			if ($urandom_range(0, 99) < 85) begin
				pick = $urandom_range(0, pool_size - 1);
				d    = pool_dest[pick];
				p    = pool_plen[pick];
			end else begin
				d = $urandom;
				p = PLEN_W'($urandom_range(0, 63));
			end
			g    = $urandom;
			f    = IFACE_W'($urandom_range(0, 255));
			roll = $urandom_range(0, 99);
			if (roll < insert_pct)
				op = CMD_INSERT;
			else if (roll < insert_pct + (100 - insert_pct) / 3)
				op = CMD_DELETE;
			else if (roll < insert_pct + 2 * (100 - insert_pct) / 3)
				op = CMD_UPDATE;
			else
				op = CMD_LOOKUP;
			// reuse the stored route now and then to reach the unchanged case
			if (op == CMD_UPDATE && $urandom_range(0, 99) < 30) begin
				for (int s = 0; s < TABLE_DEPTH; s++) begin
					if (tbl_valid[s] && tbl_key[s] == {d, p}) begin
						g = tbl_gw[s];
						f = tbl_iface[s];
					end
				end
			end
			send_route_op(op, d, p, g, f);
		end
	endtask

	task automatic test_drain_pause();
		wait_results_drained();
		send_route_op(CMD_LOOKUP, pool_dest[0], pool_plen[0], 32'h0, 8'h00);
	endtask

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_key[i]   = '0;
			tbl_gw[i]    = '0;
			tbl_iface[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_table_full();
		sender_steady = 1'b1;
		test_random_ops(150, 40, 40);
		sender_steady = 1'b0;
		test_random_ops(280, 40, 35);
		test_drain_pause();
		// larger pool, insert-heavy: drives the table to full
		test_random_ops(280, 100, 55);

		wait_results_drained();
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("exact_match_route_table_core regression: pass");
		else
			$display("exact_match_route_table_core regression: fail");
		$finish;
	end

endmodule

// File: files.f
rtl/core/emrt_pkg.sv
rtl/core/emrt_ram.sv
rtl/core/emrt_ctrl.sv
rtl/core/emrt_datapath.sv
rtl/core/exact_match_route_table_core.sv
tb/exact_match_route_table_core_test.sv
